[sv/pmsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PID motor speed controller package
// Shared types, widths and register codes of the speed controller.
// ----------------------------------------------------------------------------
package pmsc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PULSE_W    = 16;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned SPEED_W    = 24;
    localparam int unsigned TARGET_W   = 15;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned ERR_W      = 26;
    localparam int unsigned DELTA_W    = 27;
    localparam int unsigned INTEG_W    = 32;
    localparam int unsigned MUL_A_W    = 17;
    localparam int unsigned MUL_B_W    = 33;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;

    localparam logic [TARGET_W-1:0] TARGET_MAX = 15'd25600;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I_SCALED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_SCALED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = 3'd5;

    typedef struct packed {
        logic                loop_enable;
        logic [TARGET_W-1:0] target_speed;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i_scaled;
        logic [GAIN_W-1:0]   gain_d_scaled;
        logic [GAIN_W-1:0]   speed_scale;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPEED,
        S_ERROR,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_SUM,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        MUL_SPEED,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        logic     err_step;
        t_acc_op  acc_op;
        logic     out_load;
    } t_dp_cmd;

endpackage
`default_nettype wire

[sv/pid_motor_speed_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PID motor speed controller
// Converts a per-tick encoder pulse count to shaft speed and produces a
// clamped PID duty from one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction  Width
//  ticks     i_valid / o_ready, i_pulse_count     in         16
//  results   o_valid / i_ready, o_pwm_duty,       out        8, 24
//            o_shaft_speed
//  config    i_cfg_we, i_cfg_index, i_cfg_data    in         3, 16
//
//  A tick steps through the speed, error, P, I, D, sum and result states,
//  skipping the products and sum with the loop disabled; one signed 17 x 33
//  multiplier is shared by the speed, P, I and D products.
//  The result register holds a finished transaction while the next tick is
//  accepted; a stalled result only holds the sequencer in its final step.
//  Reset is synchronous and active low and loads the register defaults and
//  clears the integral and previous error.
// ----------------------------------------------------------------------------
module pid_motor_speed_controller (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [pmsc_pkg::PULSE_W-1:0]      i_pulse_count,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [pmsc_pkg::DUTY_W-1:0]       o_pwm_duty,
    output logic      [pmsc_pkg::SPEED_W-1:0]      o_shaft_speed,
    input  wire logic                              i_cfg_we,
    input  wire logic [pmsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pmsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pmsc_pkg::t_cfg    w_cfg;
    pmsc_pkg::t_dp_cmd w_cmd;

    pmsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pmsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .i_loop_enable (w_cfg.loop_enable),
        .o_cmd         (w_cmd)
    );

    pmsc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .i_pulse_count (i_pulse_count),
        .o_pwm_duty    (o_pwm_duty),
        .o_shaft_speed (o_shaft_speed)
    );

endmodule
`default_nettype wire

[sv/pmsc_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PID motor speed controller configuration registers
// Holds the enable, target, gains and speed scale written through the port.
// ----------------------------------------------------------------------------
module pmsc_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pmsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pmsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pmsc_pkg::t_cfg                          o_cfg
);

    pmsc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_enable   <= 1'b0;
            r_cfg.target_speed  <= 15'd12800;
            r_cfg.gain_p        <= 16'd512;
            r_cfg.gain_i_scaled <= 16'd13;
            r_cfg.gain_d_scaled <= 16'd256;
            r_cfg.speed_scale   <= 16'd2247;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmsc_pkg::CFG_LOOP_ENABLE:   r_cfg.loop_enable   <= i_cfg_data[0];
                pmsc_pkg::CFG_TARGET_SPEED:
                    r_cfg.target_speed <= i_cfg_data[pmsc_pkg::TARGET_W-1:0];
                pmsc_pkg::CFG_GAIN_P:        r_cfg.gain_p        <= i_cfg_data;
                pmsc_pkg::CFG_GAIN_I_SCALED: r_cfg.gain_i_scaled <= i_cfg_data;
                pmsc_pkg::CFG_GAIN_D_SCALED: r_cfg.gain_d_scaled <= i_cfg_data;
                pmsc_pkg::CFG_SPEED_SCALE:   r_cfg.speed_scale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[sv/pmsc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PID motor speed controller sequencer
// Steps each control tick through the shared multiplier and owns both
// handshakes.
// ----------------------------------------------------------------------------
module pmsc_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  wire logic        i_ready,
    input  wire logic        i_loop_enable,
    output pmsc_pkg::t_dp_cmd o_cmd
);

    pmsc_pkg::t_state r_state;
    pmsc_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmsc_pkg::S_IDLE:   if (i_valid) n_state = pmsc_pkg::S_SPEED;
            pmsc_pkg::S_SPEED:  n_state = pmsc_pkg::S_ERROR;
            pmsc_pkg::S_ERROR:  n_state = i_loop_enable ? pmsc_pkg::S_MUL_P
                                                        : pmsc_pkg::S_RESULT;
            pmsc_pkg::S_MUL_P:  n_state = pmsc_pkg::S_MUL_I;
            pmsc_pkg::S_MUL_I:  n_state = pmsc_pkg::S_MUL_D;
            pmsc_pkg::S_MUL_D:  n_state = pmsc_pkg::S_SUM;
            pmsc_pkg::S_SUM:    n_state = pmsc_pkg::S_RESULT;
            pmsc_pkg::S_RESULT: if (w_out_free) n_state = pmsc_pkg::S_IDLE;
            default:            n_state = pmsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.mul_sel  = pmsc_pkg::MUL_SPEED;
        o_cmd.err_step = 1'b0;
        o_cmd.acc_op   = pmsc_pkg::ACC_HOLD;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            pmsc_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
            end
            pmsc_pkg::S_SPEED: begin
                o_cmd.mul_sel = pmsc_pkg::MUL_SPEED;
            end
            pmsc_pkg::S_ERROR: begin
                o_cmd.err_step = 1'b1;
            end
            pmsc_pkg::S_MUL_P: begin
                o_cmd.mul_sel = pmsc_pkg::MUL_P;
            end
            pmsc_pkg::S_MUL_I: begin
                o_cmd.mul_sel = pmsc_pkg::MUL_I;
                o_cmd.acc_op  = pmsc_pkg::ACC_LOAD;
            end
            pmsc_pkg::S_MUL_D: begin
                o_cmd.mul_sel = pmsc_pkg::MUL_D;
                o_cmd.acc_op  = pmsc_pkg::ACC_ADD;
            end
            pmsc_pkg::S_SUM: begin
                o_cmd.acc_op = pmsc_pkg::ACC_ADD;
            end
            pmsc_pkg::S_RESULT: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmsc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

[sv/pmsc_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PID motor speed controller datapath
// Shared signed multiplier, error and integral registers, PID accumulator
// and the output register.
// ----------------------------------------------------------------------------
module pmsc_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pmsc_pkg::t_cfg                    i_cfg,
    input  wire pmsc_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [pmsc_pkg::PULSE_W-1:0]      i_pulse_count,
    output logic      [pmsc_pkg::DUTY_W-1:0]       o_pwm_duty,
    output logic      [pmsc_pkg::SPEED_W-1:0]      o_shaft_speed
);

    logic        [pmsc_pkg::PULSE_W-1:0] r_pulses;
    logic signed [pmsc_pkg::PROD_W-1:0]  r_prod;
    logic        [pmsc_pkg::SPEED_W-1:0] r_speed;
    logic signed [pmsc_pkg::ERR_W-1:0]   r_err;
    logic signed [pmsc_pkg::DELTA_W-1:0] r_delta;
    logic signed [pmsc_pkg::INTEG_W-1:0] r_integ;
    logic signed [pmsc_pkg::ERR_W-1:0]   r_prev;
    logic signed [pmsc_pkg::PROD_W-1:0]  r_acc;
    logic        [pmsc_pkg::DUTY_W-1:0]  r_duty_out;
    logic        [pmsc_pkg::SPEED_W-1:0] r_speed_out;

    logic signed [pmsc_pkg::MUL_A_W-1:0]   w_mul_a;
    logic signed [pmsc_pkg::MUL_B_W-1:0]   w_mul_b;
    logic        [pmsc_pkg::SPEED_W-1:0]   w_speed;
    logic        [pmsc_pkg::TARGET_W-1:0]  w_target;
    logic signed [pmsc_pkg::ERR_W-1:0]     w_err;
    logic signed [pmsc_pkg::INTEG_W:0]     w_integ_sum;
    logic signed [pmsc_pkg::INTEG_W-1:0]   w_integ;
    logic signed [pmsc_pkg::DELTA_W-1:0]   w_delta;
    logic        [pmsc_pkg::DUTY_W-1:0]    w_duty;

    always_comb begin
        unique case (i_cmd.mul_sel)
            pmsc_pkg::MUL_SPEED: begin
                w_mul_a = {1'b0, i_cfg.speed_scale};
                w_mul_b = {17'd0, r_pulses};
            end
            pmsc_pkg::MUL_P: begin
                w_mul_a = {1'b0, i_cfg.gain_p};
                w_mul_b = {{7{r_err[pmsc_pkg::ERR_W-1]}}, r_err};
            end
            pmsc_pkg::MUL_I: begin
                w_mul_a = {1'b0, i_cfg.gain_i_scaled};
                w_mul_b = {r_integ[pmsc_pkg::INTEG_W-1], r_integ};
            end
            pmsc_pkg::MUL_D: begin
                w_mul_a = {1'b0, i_cfg.gain_d_scaled};
                w_mul_b = {{6{r_delta[pmsc_pkg::DELTA_W-1]}}, r_delta};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_speed  = r_prod[31:8];
    assign w_target = (i_cfg.target_speed > pmsc_pkg::TARGET_MAX) ? pmsc_pkg::TARGET_MAX
                                                                   : i_cfg.target_speed;
    assign w_err    = $signed({11'd0, w_target}) - $signed({2'd0, w_speed});
    assign w_integ_sum = $signed({r_integ[pmsc_pkg::INTEG_W-1], r_integ})
                       + $signed({{7{w_err[pmsc_pkg::ERR_W-1]}}, w_err});
    assign w_delta  = $signed({w_err[pmsc_pkg::ERR_W-1], w_err})
                    - $signed({r_prev[pmsc_pkg::ERR_W-1], r_prev});

    always_comb begin
        w_integ = w_integ_sum[pmsc_pkg::INTEG_W-1:0];
        if (w_integ_sum[pmsc_pkg::INTEG_W] != w_integ_sum[pmsc_pkg::INTEG_W-1]) begin
            w_integ = w_integ_sum[pmsc_pkg::INTEG_W] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
    end

    always_comb begin
        w_duty = r_acc[23:16];
        if (!i_cfg.loop_enable || r_acc[pmsc_pkg::PROD_W-1]) begin
            w_duty = '0;
        end else if (|r_acc[pmsc_pkg::PROD_W-2:24]) begin
            w_duty = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_cmd.err_step && i_cfg.loop_enable) begin
            r_integ <= w_integ;
            r_prev  <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (i_cmd.load_in) begin
            r_pulses <= i_pulse_count;
        end
        if (i_cmd.err_step) begin
            r_speed <= w_speed;
            r_err   <= w_err;
            r_delta <= w_delta;
        end
        unique case (i_cmd.acc_op)
            pmsc_pkg::ACC_LOAD: r_acc <= r_prod;
            pmsc_pkg::ACC_ADD:  r_acc <= r_acc + r_prod;
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_duty_out  <= w_duty;
            r_speed_out <= r_speed;
        end
    end

    assign o_pwm_duty    = r_duty_out;
    assign o_shaft_speed = r_speed_out;

endmodule
`default_nettype wire

[dv/tb_pid_motor_speed_controller.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID motor speed controller testbench
// Sends control ticks over the valid/ready input channel and checks every
// duty and shaft speed result against a cycle-free PID predictor kept in step
// with the register writes. A short directed run covers the loop enable,
// the clamped target, unmapped register indexes, zero and full-scale gains
// and speed scales. Random phases with varied settings follow. One of
// them winds the integral into its lower bound. Random back-pressure,
// sender gaps and one long receiver hold-off are applied.
// ----------------------------------------------------------------------------
module tb_pid_motor_speed_controller;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam longint INTEG_HI = 64'sd2147483647;
    localparam longint INTEG_LO = -64'sd2147483648;
    localparam logic [pmsc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [pmsc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [pmsc_pkg::DUTY_W-1:0]  duty;
        logic [pmsc_pkg::SPEED_W-1:0] speed;
    } t_tick_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [pmsc_pkg::PULSE_W-1:0]    i_pulse_count = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [pmsc_pkg::DUTY_W-1:0]     o_pwm_duty;
    logic [pmsc_pkg::SPEED_W-1:0]    o_shaft_speed;
    logic                            i_cfg_we = 1'b0;
    logic [pmsc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pmsc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic                                 m_enable = 1'b0;
    logic [pmsc_pkg::TARGET_W-1:0]        m_target = 15'd12800;
    logic [pmsc_pkg::GAIN_W-1:0]          m_gain_p = 16'd512;
    logic [pmsc_pkg::GAIN_W-1:0]          m_gain_i = 16'd13;
    logic [pmsc_pkg::GAIN_W-1:0]          m_gain_d = 16'd256;
    logic [pmsc_pkg::GAIN_W-1:0]          m_scale = 16'd2247;
    logic signed [pmsc_pkg::INTEG_W-1:0]  m_integral = '0;
    logic signed [pmsc_pkg::ERR_W-1:0]    m_prev_err = '0;

    logic [pmsc_pkg::PULSE_W-1:0] tick_queue[$];
    t_tick_result       expected_results[$];
    int unsigned        ticks_queued = 0;
    int unsigned        ticks_accepted = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        sender_idle_pct = 34;
    int unsigned        receiver_idle_pct = 59;
    int unsigned        hold_left = 0;
    bit                 hold_request = 1'b0;
    bit                 tick_taken = 1'b0;

    pid_motor_speed_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pulse_count (i_pulse_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pwm_duty    (o_pwm_duty),
        .o_shaft_speed (o_shaft_speed),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_tick_result predict_tick(input logic [pmsc_pkg::PULSE_W-1:0] pulses);
        longint       speed;
        longint       target;
        longint       err;
        longint       integ;
        longint       delta;
        longint       sum;
        t_tick_result res;
        speed = (longint'(pulses) * longint'(m_scale)) >>> 8;
        res.speed = speed[pmsc_pkg::SPEED_W-1:0];
        res.duty = '0;
        if (m_enable) begin
            target = (m_target > pmsc_pkg::TARGET_MAX) ? longint'(pmsc_pkg::TARGET_MAX)
                                                       : longint'(m_target);
            err = target - speed;
            integ = longint'(m_integral) + err;
            if (integ > INTEG_HI) begin
                integ = INTEG_HI;
            end
            if (integ < INTEG_LO) begin
                integ = INTEG_LO;
            end
            delta = err - longint'(m_prev_err);
            m_integral = integ[pmsc_pkg::INTEG_W-1:0];
            m_prev_err = err[pmsc_pkg::ERR_W-1:0];
            sum = longint'(m_gain_p) * err + longint'(m_gain_i) * integ
                + longint'(m_gain_d) * delta;
            if (sum >= 0) begin
                res.duty = ((sum >>> 16) > 255) ? 8'hFF : sum[23:16];
            end
        end
        return res;
    endfunction

    function automatic logic [pmsc_pkg::PULSE_W-1:0] pick_pulses();
        int unsigned roll;
        int          center;
        int          pulses;
        roll = $urandom_range(99);
        center = 0;
        if (m_scale != 0) begin
            center = ((m_target > pmsc_pkg::TARGET_MAX) ? int'(pmsc_pkg::TARGET_MAX)
                                                        : int'(m_target)) * 256
                   / int'(m_scale);
        end
        if (roll < 60) begin
            pulses = center + int'($urandom_range(64)) - 32;
        end else if (roll < 75) begin
            pulses = $urandom_range(255);
        end else if (roll < 90) begin
            pulses = $urandom_range(65535);
        end else begin
            pulses = ($urandom_range(1) != 0) ? 65535 : 0;
        end
        if (pulses < 0) begin
            pulses = 0;
        end
        if (pulses > 65535) begin
            pulses = 65535;
        end
        return pulses[pmsc_pkg::PULSE_W-1:0];
    endfunction

    function automatic logic [pmsc_pkg::GAIN_W-1:0] pick_gain();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return 16'hFFFF;
        end else if (roll < 6) begin
            return 16'($urandom_range(1023));
        end
        return 16'($urandom_range(65535));
    endfunction

    // Input side: prediction at acceptance, new payload at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(predict_tick(i_pulse_count));
            ticks_accepted++;
            tick_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tick_taken) begin
            tick_taken = 1'b0;
            if (tick_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_valid <= 1'b1;
                i_pulse_count <= tick_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tick_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected transaction: duty %0d, speed %0d", o_pwm_duty, o_shaft_speed);
                mismatch_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_pwm_duty !== exp_res.duty) begin
                    $error("pwm_duty mismatch: expected %0d, actual %0d",
                           exp_res.duty, o_pwm_duty);
                    mismatch_count++;
                end
                if (o_shaft_speed !== exp_res.speed) begin
                    $error("shaft_speed mismatch: expected %0d, actual %0d",
                           exp_res.speed, o_shaft_speed);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_tick(input logic [pmsc_pkg::PULSE_W-1:0] pulses);
        tick_queue.push_back(pulses);
        ticks_queued++;
    endtask

    task automatic wait_drain();
        do begin
            @(negedge i_clk);
        end while (ticks_accepted != ticks_queued || expected_results.size() != 0);
    endtask

    task automatic set_reg(input logic [pmsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmsc_pkg::CFG_DATA_W-1:0] data);
        wait_drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            pmsc_pkg::CFG_LOOP_ENABLE:   m_enable = data[0];
            pmsc_pkg::CFG_TARGET_SPEED:  m_target = data[pmsc_pkg::TARGET_W-1:0];
            pmsc_pkg::CFG_GAIN_P:        m_gain_p = data;
            pmsc_pkg::CFG_GAIN_I_SCALED: m_gain_i = data;
            pmsc_pkg::CFG_GAIN_D_SCALED: m_gain_d = data;
            pmsc_pkg::CFG_SPEED_SCALE:   m_scale = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic randomize_settings();
        int unsigned roll;
        set_reg(pmsc_pkg::CFG_LOOP_ENABLE, ($urandom_range(9) != 0) ? 16'h0001
                                           : (16'($urandom) & 16'hFFFE));
        roll = $urandom_range(9);
        if (roll == 0) begin
            set_reg(pmsc_pkg::CFG_TARGET_SPEED, 16'd0);
        end else if (roll == 1) begin
            set_reg(pmsc_pkg::CFG_TARGET_SPEED, 16'd25600);
        end else if (roll == 2) begin
            set_reg(pmsc_pkg::CFG_TARGET_SPEED, 16'hFFFF);
        end else begin
            set_reg(pmsc_pkg::CFG_TARGET_SPEED, 16'($urandom_range(65535)));
        end
        set_reg(pmsc_pkg::CFG_GAIN_P, pick_gain());
        set_reg(pmsc_pkg::CFG_GAIN_I_SCALED, pick_gain());
        set_reg(pmsc_pkg::CFG_GAIN_D_SCALED, pick_gain());
        roll = $urandom_range(9);
        if (roll == 0) begin
            set_reg(pmsc_pkg::CFG_SPEED_SCALE, 16'hFFFF);
        end else if (roll == 1) begin
            set_reg(pmsc_pkg::CFG_SPEED_SCALE, 16'($urandom_range(65535, 1)));
        end else begin
            set_reg(pmsc_pkg::CFG_SPEED_SCALE, 16'($urandom_range(8192, 256)));
        end
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) begin
            queue_tick(pick_pulses());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: disabled loop first, then enabled at the reset defaults.
        queue_tick(16'd0);
        queue_tick(16'hFFFF);
        queue_tick(16'd1458);
        set_reg(CFG_UNMAPPED_LO, 16'hFFFF);
        set_reg(CFG_UNMAPPED_HI, 16'hFFFF);
        set_reg(pmsc_pkg::CFG_LOOP_ENABLE, 16'h0001);
        queue_tick(16'd0);
        queue_tick(16'hFFFF);
        queue_tick(16'd1458);
        queue_tick(16'd1458);
        queue_tick(16'd1500);
        set_reg(pmsc_pkg::CFG_TARGET_SPEED, 16'h7FFF);
        queue_tick(16'd0);
        queue_tick(16'd1458);
        set_reg(pmsc_pkg::CFG_TARGET_SPEED, 16'd0);
        queue_tick(16'd1458);
        queue_tick(16'd0);
        set_reg(pmsc_pkg::CFG_GAIN_P, 16'd0);
        set_reg(pmsc_pkg::CFG_GAIN_I_SCALED, 16'd0);
        set_reg(pmsc_pkg::CFG_GAIN_D_SCALED, 16'd0);
        queue_tick(16'd100);
        set_reg(pmsc_pkg::CFG_TARGET_SPEED, 16'd25600);
        set_reg(pmsc_pkg::CFG_GAIN_P, 16'hFFFF);
        set_reg(pmsc_pkg::CFG_GAIN_I_SCALED, 16'hFFFF);
        set_reg(pmsc_pkg::CFG_GAIN_D_SCALED, 16'hFFFF);
        queue_tick(16'd0);
        queue_tick(16'hFFFF);
        queue_tick(16'd1458);
        set_reg(pmsc_pkg::CFG_SPEED_SCALE, 16'd0);
        queue_tick(16'hFFFF);
        set_reg(pmsc_pkg::CFG_SPEED_SCALE, 16'hFFFF);
        queue_tick(16'hFFFF);
        set_reg(pmsc_pkg::CFG_LOOP_ENABLE, 16'hFFFE);
        queue_tick(16'd1000);

        // Random phase with a long receiver hold-off while ticks keep coming.
        sender_idle_pct = 34;
        receiver_idle_pct = 59;
        randomize_settings();
        run_random(300);
        hold_request = 1'b1;

        // Integral windup: large negative errors drive it to its lower bound.
        wait_drain();
        sender_idle_pct = 59;
        receiver_idle_pct = 34;
        set_reg(pmsc_pkg::CFG_LOOP_ENABLE, 16'h0001);
        set_reg(pmsc_pkg::CFG_SPEED_SCALE, 16'hFFFF);
        set_reg(pmsc_pkg::CFG_GAIN_P, pick_gain());
        set_reg(pmsc_pkg::CFG_GAIN_I_SCALED, 16'($urandom_range(65535, 1)));
        set_reg(pmsc_pkg::CFG_GAIN_D_SCALED, pick_gain());
        repeat (140) begin
            queue_tick(16'($urandom_range(65535, 50000)));
        end
        run_random(10);

        wait_drain();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (3) begin
            randomize_settings();
            run_random(150);
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
